@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

@@ hw/rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int OCC_W   = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    op_t                        operation;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [PRIO_W-1:0]   item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  result_value;
    status_t                    status;
    logic [OCC_W-1:0]           occupancy;
  } out_item_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                       insert;
    logic                       remove;
    logic signed [VALUE_W-1:0]  new_value;
    logic signed [PRIO_W-1:0]   new_prio;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
`default_nettype none
module spq_cell (
  input  wire logic                              clk,
  input  wire spq_pkg::cell_cmd_t                cmd,
  input  wire logic                              occupied,
  input  wire logic                              left_keep,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]  left_prio,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]  right_prio,
  output logic                                   keep,
  output logic signed [spq_pkg::VALUE_W-1:0]     value,
  output logic signed [spq_pkg::PRIO_W-1:0]      prio
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic signed [PRIO_W-1:0]  prio_r, prio_nxt;

  // On an insert, an occupied entry stays put when it sorts at or ahead of the new item.
  assign keep  = occupied && (prio_r <= cmd.new_prio);
  assign value = value_r;
  assign prio  = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.insert && !keep) begin
      if (left_keep) begin
        value_nxt = cmd.new_value;
        prio_nxt  = cmd.new_prio;
      end else begin
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end
    end else if (cmd.remove) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_priority_queue_top.sv @@
`default_nettype none
// Sorted priority queue: CAPACITY entries kept in ascending priority order,
// lower priority number served first, equal priorities in arrival order.
//
// Input channel: an item is taken on a rising edge with start high and busy
// low. in_item.operation selects insert (value and priority are stored) or
// remove (head entry is returned). busy stays low: the block takes one item
// in every cycle.
//
// Result channel: out_valid pulses for one cycle, in the cycle after the item
// was taken, with out_item carrying the removed value (-1 on an empty queue,
// 0 for inserts), the status code and the occupancy after the operation.
// Throughput is 1 item per cycle, set by the row of cells: every cell
// compares its priority with the new one and loads its own entry, its left
// or right neighbor's, or the new item in the same cycle.
//
// The receiver cannot stall; each result is shown exactly once.
// Reset empties the queue (entry count to zero) and drops any pending strobe;
// cell contents are not cleared and never reach a result beyond the count.
module sorted_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire spq_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output spq_pkg::out_item_t       out_item
);
  import spq_pkg::*;

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;

  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  cell_cmd_t                  cmd;

  logic                       keeps [CAPACITY];
  logic signed [VALUE_W-1:0]  vals  [CAPACITY];
  logic signed [PRIO_W-1:0]   prios [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  // Broadcast the command; drop inserts on full and removes on empty.
  always_comb begin
    cmd.insert    = accept && (in_item.operation == OP_INSERT) && !is_full;
    cmd.remove    = accept && (in_item.operation == OP_REMOVE) && !is_empty;
    cmd.new_value = in_item.item_value;
    cmd.new_prio  = in_item.item_priority;
  end

  // Row of cells, head at index 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_keep;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [PRIO_W-1:0]  left_prio;
    logic signed [VALUE_W-1:0] right_value;
    logic signed [PRIO_W-1:0]  right_prio;

    if (i == 0) begin : g_head
      // Nothing sorts ahead of the head: it takes the new item directly.
      assign left_keep  = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_body
      assign left_keep  = keeps[i-1];
      assign left_value = vals[i-1];
      assign left_prio  = prios[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_inner
      assign right_value = vals[i+1];
      assign right_prio  = prios[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < count_r),
      .left_keep   (left_keep),
      .left_value  (left_value),
      .left_prio   (left_prio),
      .right_value (right_value),
      .right_prio  (right_prio),
      .keep        (keeps[i]),
      .value       (vals[i]),
      .prio        (prios[i])
    );
  end

  // Advance the count and build the result of this item.
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CNT_W'(1);
    end

    out_item_nxt.result_value = '0;
    out_item_nxt.status       = STATUS_DONE;
    out_item_nxt.occupancy    = OCC_W'(count_nxt);
    case (in_item.operation)
      OP_INSERT: begin
        if (is_full) begin
          out_item_nxt.status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          out_item_nxt.result_value = EMPTY_VALUE;
          out_item_nxt.status       = STATUS_EMPTY;
        end else begin
          out_item_nxt.result_value = vals[0];
        end
      end
      default: begin
        out_item_nxt.status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Hold the result payload for its strobe cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SPQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid)
  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n,
    accept && (in_item.operation == OP_INSERT) && !is_full,
    count_r == $past(count_r) + CNT_W'(1))
  `SPQ_ASSERT_IMPLY(a_full_flag, clk, rst_n,
    out_valid && (out_item.status == STATUS_FULL), is_full)

endmodule
`default_nettype wire
